FILE: hw/rtl/cbhc_pkg.sv
// cbhc_pkg: shared types, constants and the hash step for the blob header checker
// depends on nothing; imported by every cbhc module and the top level
package cbhc_pkg;

	localparam int HDR_BYTES      = 76;
	localparam int HDR_POS_BITS   = 7;
	localparam int FIXED_END      = 16;
	localparam int ID_END         = 60;
	localparam int LEN_POS        = 67;
	localparam int ID_BYTES       = ID_END - FIXED_END;
	localparam int ID_IDX_BITS    = $clog2(ID_BYTES);
	localparam int COUNT_BITS_DEF = 33;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 64;

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

	// magic, file version 1 and header size, little-endian, byte 0 in low bits
	localparam logic [127:0] FIXED_HDR = {32'd76, 32'd1, 64'h43504B5636323141};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_API_VERSION    = 3'd0,
		REG_KEY_SCHEMA     = 3'd1,
		REG_SHADER_ABI     = 3'd2,
		REG_VENDOR_DEVICE  = 3'd3,
		REG_DRIVER_VERSION = 3'd4,
		REG_UUID_LOW       = 3'd5,
		REG_UUID_HIGH      = 3'd6,
		REG_MAX_PAYLOAD    = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_BAD_HDR   = 3'd2,
		ST_IDENTITY  = 3'd3,
		ST_TOO_LARGE = 3'd4,
		ST_CHECKSUM  = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0] api_version;
		logic [31:0] key_schema;
		logic [63:0] shader_abi;
		logic [63:0] vendor_device;
		logic [31:0] driver_version;
		logic [63:0] uuid_low;
		logic [63:0] uuid_high;
		logic [31:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic                    step;
		logic                    in_hdr;
		logic [HDR_POS_BITS-1:0] pos;
		logic                    clear;
	} step_ctl_t;

	typedef struct packed {
		logic        hdr_bad;
		logic        id_bad;
		logic [63:0] stored_length;
		logic [63:0] stored_sum;
		logic [63:0] hash;
	} snap_t;

	// fnv-1a step; prime is 2^40 + 0x1b3, so the product is a sum of shifts
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

FILE: hw/rtl/cbhc_header.sv
// cbhc_header: header byte checks, identity compare and stored field capture
// depends on cbhc_pkg
module cbhc_header (
	input  logic                clk,
	input  logic                arst_n,
	input  cbhc_pkg::step_ctl_t ctl,
	input  logic [7:0]          data_byte,
	input  cbhc_pkg::cfg_t      cfg,
	output logic                hdr_bad_next,
	output logic                id_bad_next,
	output logic [63:0]         stored_length_next,
	output logic [63:0]         field_shift_next
);
	import cbhc_pkg::*;

	logic [63:0]                  field_shift_q;
	logic [63:0]                  stored_length_q;
	logic                         hdr_bad_q;
	logic                         id_bad_q;
	logic [ID_BYTES*8-1:0]        id_vec;
	logic [HDR_POS_BITS-1:0]      id_off;
	logic [ID_IDX_BITS-1:0]       id_idx;
	logic                         in_fixed;
	logic                         in_id;
	logic                         fixed_mis;
	logic                         id_mis;

	assign id_vec = {cfg.uuid_high, cfg.uuid_low, cfg.driver_version,
		cfg.vendor_device[31:0], cfg.vendor_device[63:32],
		cfg.shader_abi, cfg.key_schema, cfg.api_version};

	assign id_off   = ctl.pos - HDR_POS_BITS'(FIXED_END);
	assign id_idx   = id_off[ID_IDX_BITS-1:0];
	assign in_fixed = ctl.in_hdr && (ctl.pos < HDR_POS_BITS'(FIXED_END));
	assign in_id    = ctl.in_hdr && !in_fixed && (ctl.pos < HDR_POS_BITS'(ID_END));

	assign fixed_mis = in_fixed && (data_byte != FIXED_HDR[{ctl.pos[3:0], 3'b000} +: 8]);
	assign id_mis    = in_id && (data_byte != id_vec[{id_idx, 3'b000} +: 8]);

	assign field_shift_next = ctl.in_hdr ? {data_byte, field_shift_q[63:8]} : field_shift_q;
	assign hdr_bad_next     = hdr_bad_q | fixed_mis;
	assign id_bad_next      = id_bad_q | id_mis;
	assign stored_length_next =
		(ctl.in_hdr && (ctl.pos == HDR_POS_BITS'(LEN_POS))) ? field_shift_next
		                                                    : stored_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_shift_q   <= '0;
			stored_length_q <= '0;
			hdr_bad_q       <= 1'b0;
			id_bad_q        <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.clear) begin
				field_shift_q   <= '0;
				stored_length_q <= '0;
				hdr_bad_q       <= 1'b0;
				id_bad_q        <= 1'b0;
			end else begin
				field_shift_q   <= field_shift_next;
				stored_length_q <= stored_length_next;
				hdr_bad_q       <= hdr_bad_next;
				id_bad_q        <= id_bad_next;
			end
		end
	end

endmodule

FILE: hw/rtl/cbhc_hash.sv
// cbhc_hash: running fnv-1a 64 over the payload bytes
// depends on cbhc_pkg
module cbhc_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  cbhc_pkg::step_ctl_t ctl,
	input  logic [7:0]          data_byte,
	output logic [63:0]         hash_next
);
	import cbhc_pkg::*;

	logic [63:0] hash_q;

	assign hash_next = ctl.in_hdr ? hash_q : fnv_step(hash_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (ctl.step) begin
			hash_q <= ctl.clear ? FNV_BASIS : hash_next;
		end
	end

endmodule

FILE: hw/rtl/cbhc_verdict.sv
// cbhc_verdict: end-of-blob snapshot stage, status priority and output register
// depends on cbhc_pkg
module cbhc_verdict #(
	parameter int COUNT_BITS = cbhc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [COUNT_BITS-1:0] n_in,
	input  cbhc_pkg::snap_t       snap,
	input  logic [31:0]           limit,
	output logic                  ready,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [31:0]           payload_length
);
	import cbhc_pkg::*;

	logic                  s2_valid;
	logic [COUNT_BITS-1:0] n_s2;
	snap_t                 snap_s2;
	logic                  out_ready;
	logic                  below;
	logic                  sat;
	logic [63:0]           plen;
	logic [63:0]           limit64;
	status_t               status_c;
	logic [31:0]           plen_c;
	logic                  out_valid_q;
	logic [2:0]            status_q;
	logic [31:0]           plen_q;

	assign out_ready = !out_valid_q || !out_stall;
	assign ready     = !s2_valid || out_ready;

	assign below   = n_s2 < COUNT_BITS'(HDR_BYTES);
	assign sat     = &n_s2;
	assign plen    = below ? 64'd0 : (64'(n_s2) - 64'(HDR_BYTES));
	assign limit64 = {32'd0, limit};

	always_comb begin
		priority if (below) begin
			status_c = ST_TRUNCATED;
		end else if (sat || (plen > limit64)) begin
			status_c = ST_TOO_LARGE;
		end else if (snap_s2.hdr_bad) begin
			status_c = ST_BAD_HDR;
		end else if (snap_s2.id_bad) begin
			status_c = ST_IDENTITY;
		end else if (snap_s2.stored_length > limit64) begin
			status_c = ST_TOO_LARGE;
		end else if (snap_s2.stored_length != plen) begin
			status_c = ST_TRUNCATED;
		end else if (snap_s2.hash != snap_s2.stored_sum) begin
			status_c = ST_CHECKSUM;
		end else begin
			status_c = ST_ACCEPTED;
		end
	end

	assign plen_c = (sat || (|plen[63:32])) ? 32'hFFFF_FFFF : plen[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready) begin
				s2_valid <= load;
			end
			if (out_ready) begin
				out_valid_q <= s2_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			n_s2    <= n_in;
			snap_s2 <= snap;
		end
		if (out_ready && s2_valid) begin
			status_q <= status_c;
			plen_q   <= plen_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_length = plen_q;

endmodule

FILE: hw/rtl/cache_blob_header_checker_unit.sv
// cache_blob_header_checker_unit: byte-stream cache blob header check and payload hash
// result path: after the last byte is accepted it passes the input reg, the snapshot stage and the output register
// throughput: one byte per cycle, except while a last byte waits for the snapshot stage
// reset: asynchronous, clears handshake state, counter, flags, config registers, hash to basis
// depends on cbhc_pkg, cbhc_header, cbhc_hash, cbhc_verdict
module cache_blob_header_checker_unit #(
	parameter int COUNT_BITS = cbhc_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               last_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic [31:0]                        payload_length,
	input  logic                               cfg_write_enable,
	input  logic [cbhc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [cbhc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import cbhc_pkg::*;

	cfg_t                  cfg_q;
	logic                  s1_valid;
	logic [7:0]            data_s1;
	logic                  last_s1;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  accept;
	logic                  s1_fire;
	logic                  v_ready;
	step_ctl_t             ctl;
	snap_t                 snap;
	logic                  hdr_bad_next;
	logic                  id_bad_next;
	logic [63:0]           stored_length_next;
	logic [63:0]           field_shift_next;
	logic [63:0]           hash_next;
	logic                  u_verdict_s2_seen;
	logic                  last_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_enable) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_API_VERSION:    cfg_q.api_version    <= cfg_data[31:0];
				REG_KEY_SCHEMA:     cfg_q.key_schema     <= cfg_data[31:0];
				REG_SHADER_ABI:     cfg_q.shader_abi     <= cfg_data;
				REG_VENDOR_DEVICE:  cfg_q.vendor_device  <= cfg_data;
				REG_DRIVER_VERSION: cfg_q.driver_version <= cfg_data[31:0];
				REG_UUID_LOW:       cfg_q.uuid_low       <= cfg_data;
				REG_UUID_HIGH:      cfg_q.uuid_high      <= cfg_data;
				REG_MAX_PAYLOAD:    cfg_q.max_payload    <= cfg_data[31:0];
			endcase
		end
	end

	// a last beat waits for the snapshot stage; other beats always go
	assign s1_fire  = s1_valid && (!last_s1 || v_ready);
	assign in_stall = s1_valid && !s1_fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign count_inc = (&count_q) ? count_q : count_q + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s1_fire) begin
			count_q <= last_s1 ? '0 : count_inc;
		end
	end

	assign ctl.step   = s1_fire;
	assign ctl.in_hdr = count_q < COUNT_BITS'(HDR_BYTES);
	assign ctl.pos    = count_q[HDR_POS_BITS-1:0];
	assign ctl.clear  = s1_fire && last_s1;

	cbhc_header u_header (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.data_byte          (data_s1),
		.cfg                (cfg_q),
		.hdr_bad_next       (hdr_bad_next),
		.id_bad_next        (id_bad_next),
		.stored_length_next (stored_length_next),
		.field_shift_next   (field_shift_next)
	);

	cbhc_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (data_s1),
		.hash_next (hash_next)
	);

	// the stored checksum is the last eight header bytes, still in the shift reg
	assign snap.hdr_bad       = hdr_bad_next;
	assign snap.id_bad        = id_bad_next;
	assign snap.stored_length = stored_length_next;
	assign snap.stored_sum    = field_shift_next;
	assign snap.hash          = hash_next;

	cbhc_verdict #(
		.COUNT_BITS (COUNT_BITS)
	) u_verdict (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (ctl.clear),
		.n_in           (count_inc),
		.snap           (snap),
		.limit          (cfg_q.max_payload),
		.ready          (v_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.payload_length (payload_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pending_q <= 1'b0;
		end else if (ctl.clear) begin
			last_pending_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			last_pending_q <= 1'b0;
		end
	end

	assign u_verdict_s2_seen = last_pending_q;

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (count_q == '0))
		else $error("byte counter not cleared after last beat");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(&count_q) |=> ((&count_q) || (count_q == '0)))
		else $error("byte counter wrapped");

	a_out_from_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(u_verdict_s2_seen))
		else $error("result without a last beat");

endmodule

FILE: tb/cache_blob_header_checker_unit_tb.sv
// cache_blob_header_checker_unit_tb: self-checking bench for the blob header checker
// streams well-formed and damaged blobs, predicts every verdict and compares it
// depends on cbhc_pkg and cache_blob_header_checker_unit
module cache_blob_header_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbhc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int HDR_LEN = 76;
	localparam logic [63:0] FNV_OFFSET = 64'd14695981039346656037;
	localparam logic [63:0] HASH_MULT = 64'd1099511628211;
	localparam logic [127:0] FIXED_WORD = {32'd76, 32'd1, 64'h43504B5636323141};

	typedef enum {
		BLOB_GOOD, BLOB_BAD_MAGIC, BLOB_BAD_VERSION, BLOB_BAD_SIZE, BLOB_BAD_ID,
		BLOB_LEN_OVER, BLOB_LEN_DIFF, BLOB_BAD_SUM, BLOB_SHORT, BLOB_NOISE
	} blob_kind_t;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} beat_t;

	typedef struct {
		status_t     st;
		logic [31:0] plen;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'd0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [31:0] payload_length;
	logic cfg_write_enable = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	beat_t byte_queue[$];
	verdict_t verdicts_due[$];
	beat_t next_beat;
	verdict_t got_due;

	cfg_t m_cfg;
	logic [32:0] m_count;
	logic [63:0] m_shift;
	logic m_hdr_bad;
	logic m_id_bad;
	logic [63:0] m_len;
	logic [63:0] m_sum;
	logic [63:0] m_hash;

	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_kick = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int error_count = 0;
	int bytes_accepted = 0;
	int blobs_sent = 0;
	int verdicts_checked = 0;
	int status_seen[6];

	cache_blob_header_checker_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_length(payload_length),
		.cfg_write_enable(cfg_write_enable),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * HASH_MULT;
	endfunction

	function automatic logic [7:0] id_byte(input int p);
		logic [63:0] w;
		int k;
		if (p < 20) begin
			w = m_cfg.api_version;
			k = p - 16;
		end else if (p < 24) begin
			w = m_cfg.key_schema;
			k = p - 20;
		end else if (p < 32) begin
			w = m_cfg.shader_abi;
			k = p - 24;
		end else if (p < 36) begin
			w = m_cfg.vendor_device[63:32];
			k = p - 32;
		end else if (p < 40) begin
			w = m_cfg.vendor_device[31:0];
			k = p - 36;
		end else if (p < 44) begin
			w = m_cfg.driver_version;
			k = p - 40;
		end else if (p < 52) begin
			w = m_cfg.uuid_low;
			k = p - 44;
		end else begin
			w = m_cfg.uuid_high;
			k = p - 52;
		end
		return w[k*8 +: 8];
	endfunction

	function automatic void clear_blob_state();
		m_count = '0;
		m_shift = '0;
		m_hdr_bad = 1'b0;
		m_id_bad = 1'b0;
		m_len = '0;
		m_sum = '0;
		m_hash = FNV_OFFSET;
	endfunction

	function automatic void predict_beat(input logic [7:0] b, input logic fin);
		int p;
		logic [32:0] n;
		logic [63:0] plen;
		logic [63:0] lim;
		logic sat;
		verdict_t v;
		if (m_count < HDR_LEN) begin
			p = int'(m_count[6:0]);
			m_shift = {b, m_shift[63:8]};
			if (p < 16) begin
				if (b != FIXED_WORD[p*8 +: 8]) m_hdr_bad = 1'b1;
			end else if (p < 60) begin
				if (b != id_byte(p)) m_id_bad = 1'b1;
			end else if (p == 67) begin
				m_len = m_shift;
			end else if (p == 75) begin
				m_sum = m_shift;
			end
		end else begin
			m_hash = hash_byte(m_hash, b);
		end
		if (m_count != '1) m_count = m_count + 1'b1;
		if (fin) begin
			n = m_count;
			sat = (n == '1);
			plen = (n < HDR_LEN) ? 64'd0 : 64'(n) - 64'(HDR_LEN);
			lim = 64'(m_cfg.max_payload);
			if (n < HDR_LEN) v.st = ST_TRUNCATED;
			else if (sat || plen > lim) v.st = ST_TOO_LARGE;
			else if (m_hdr_bad) v.st = ST_BAD_HDR;
			else if (m_id_bad) v.st = ST_IDENTITY;
			else if (m_len > lim) v.st = ST_TOO_LARGE;
			else if (m_len != plen) v.st = ST_TRUNCATED;
			else if (m_hash != m_sum) v.st = ST_CHECKSUM;
			else v.st = ST_ACCEPTED;
			v.plen = (sat || plen > 64'hFFFFFFFF) ? 32'hFFFFFFFF : plen[31:0];
			verdicts_due.insert(verdicts_due.size(), v);
			clear_blob_state();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// beat source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			last_byte <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				predict_beat(data_byte, last_byte);
				bytes_accepted++;
			end
			if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_beat = byte_queue.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_beat.b;
				last_byte <= next_beat.fin;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_left <= 0;
		else if (hold_kick) hold_left <= HOLD_CYCLES;
		else if (hold_left != 0) hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// verdict checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("verdict status %0d length %0d with none pending",
					status, payload_length));
			end else begin
				got_due = verdicts_due.pop_front();
				verdicts_checked++;
				status_seen[int'(got_due.st)]++;
				if (status !== got_due.st)
					report_mismatch($sformatf("status %0d, predicted %0d", status, got_due.st));
				if (payload_length !== got_due.plen)
					report_mismatch($sformatf("payload_length %0d, predicted %0d",
						payload_length, got_due.plen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR timeout with %0d verdicts outstanding", verdicts_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
		@(posedge clk);
		cfg_write_enable <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_API_VERSION:    m_cfg.api_version = v[31:0];
			REG_KEY_SCHEMA:     m_cfg.key_schema = v[31:0];
			REG_SHADER_ABI:     m_cfg.shader_abi = v;
			REG_VENDOR_DEVICE:  m_cfg.vendor_device = v;
			REG_DRIVER_VERSION: m_cfg.driver_version = v[31:0];
			REG_UUID_LOW:       m_cfg.uuid_low = v;
			REG_UUID_HIGH:      m_cfg.uuid_high = v;
			REG_MAX_PAYLOAD:    m_cfg.max_payload = v[31:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int s);
		logic [63:0] v;
		for (int i = 0; i < 8; i++) begin
			case (s)
				1: v = '1;
				2: v = '0;
				default: v = {$urandom, $urandom};
			endcase
			if (s == 0 && cfg_reg_t'(i) == REG_MAX_PAYLOAD)
				v = {$urandom, 32'($urandom_range(0, 16))};
			write_reg(cfg_reg_t'(i), v);
		end
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic build_blob(input blob_kind_t kind, input int plen, output int nb);
		logic [7:0] blob[$];
		logic [7:0] pay[$];
		logic [7:0] b;
		logic [63:0] h;
		logic [63:0] slen;
		logic [63:0] ssum;
		int cut;
		beat_t bt;
		cut = -1;
		if (kind == BLOB_SHORT) begin
			cut = plen;
			plen = 0;
		end
		h = FNV_OFFSET;
		for (int i = 0; i < plen; i++) begin
			b = 8'($urandom);
			pay.insert(pay.size(), b);
			h = hash_byte(h, b);
		end
		slen = 64'(plen);
		ssum = h;
		if (kind == BLOB_LEN_OVER) begin
			if ($urandom_range(1)) slen = {$urandom, $urandom} | 64'h1_0000_0000;
			else slen = 64'(m_cfg.max_payload) + 64'd1 + 64'($urandom_range(0, 1000));
		end else if (kind == BLOB_LEN_DIFF) begin
			slen = slen ^ (64'd1 << $urandom_range(0, 63));
		end else if (kind == BLOB_BAD_SUM) begin
			ssum = ssum ^ (64'd1 << $urandom_range(0, 63));
		end
		for (int i = 0; i < 16; i++) blob.insert(blob.size(), FIXED_WORD[i*8 +: 8]);
		for (int i = 16; i < 60; i++) blob.insert(blob.size(), id_byte(i));
		for (int i = 0; i < 8; i++) blob.insert(blob.size(), slen[i*8 +: 8]);
		for (int i = 0; i < 8; i++) blob.insert(blob.size(), ssum[i*8 +: 8]);
		case (kind)
			BLOB_BAD_MAGIC:   blob[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
			BLOB_BAD_VERSION: blob[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
			BLOB_BAD_SIZE:    blob[$urandom_range(12, 15)] ^= 8'($urandom_range(1, 255));
			BLOB_BAD_ID:      blob[$urandom_range(16, 59)] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
		blob = {blob, pay};
		if (cut > 0) blob = blob[0:cut-1];
		if (kind == BLOB_NOISE) begin
			blob.delete();
			repeat ($urandom_range(1, 120)) blob.insert(blob.size(), 8'($urandom));
		end
		nb = blob.size();
		for (int i = 0; i < nb; i++) begin
			bt.b = blob[i];
			bt.fin = (i == nb - 1);
			byte_queue.insert(byte_queue.size(), bt);
		end
		blobs_sent++;
	endtask

	function automatic blob_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 45) return BLOB_GOOD;
		if (r < 50) return BLOB_BAD_MAGIC;
		if (r < 54) return BLOB_BAD_VERSION;
		if (r < 58) return BLOB_BAD_SIZE;
		if (r < 66) return BLOB_BAD_ID;
		if (r < 72) return BLOB_LEN_OVER;
		if (r < 78) return BLOB_LEN_DIFF;
		if (r < 86) return BLOB_BAD_SUM;
		if (r < 93) return BLOB_SHORT;
		return BLOB_NOISE;
	endfunction

	function automatic int pick_plen();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(0, 8);
		if (r < 85) return $urandom_range(0, 200);
		if (m_cfg.max_payload <= 200) return int'(m_cfg.max_payload) + $urandom_range(0, 1);
		return $urandom_range(0, 8);
	endfunction

	task automatic set_mix(input int m);
		case (m)
			1: begin idle_pct = 64; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 64; end
			3: begin idle_pct = 36; stall_pct = 36; end
			default: begin idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	initial begin
		int nb;
		int seg_bytes;
		int lim;
		blob_kind_t kind;
		m_cfg = '0;
		clear_blob_state();
		for (int i = 0; i < 6; i++) status_seen[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// registers at reset: zero identity, zero payload limit
		build_blob(BLOB_SHORT, 1, nb);
		build_blob(BLOB_SHORT, 75, nb);
		build_blob(BLOB_GOOD, 0, nb);
		build_blob(BLOB_GOOD, 1, nb);
		wait_idle();

		apply_setting(0);
		lim = int'(m_cfg.max_payload);
		build_blob(BLOB_GOOD, 0, nb);
		build_blob(BLOB_GOOD, lim, nb);
		build_blob(BLOB_GOOD, lim + 1, nb);
		build_blob(BLOB_BAD_MAGIC, 2, nb);
		build_blob(BLOB_BAD_VERSION, 2, nb);
		build_blob(BLOB_BAD_SIZE, 2, nb);
		build_blob(BLOB_BAD_ID, 2, nb);
		build_blob(BLOB_LEN_OVER, 0, nb);
		build_blob(BLOB_LEN_DIFF, 3, nb);
		build_blob(BLOB_BAD_SUM, 3, nb);
		build_blob(BLOB_NOISE, 0, nb);
		wait_idle();

		for (int s = 0; s < 4; s++) begin
			apply_setting((s + 1) % 4);
			set_mix(s % 4);
			seg_bytes = 0;
			while (seg_bytes < 110) begin
				kind = pick_kind();
				build_blob(kind, (kind == BLOB_SHORT) ? $urandom_range(1, 75) : pick_plen(), nb);
				seg_bytes += nb;
			end
			wait_idle();
		end

		// long receiver hold while beats keep coming
		set_mix(0);
		apply_setting(3);
		for (int i = 0; i < 3; i++) build_blob(BLOB_GOOD, $urandom_range(0, 3), nb);
		build_blob(BLOB_SHORT, $urandom_range(1, 75), nb);
		@(posedge clk);
		hold_kick <= 1'b1;
		@(posedge clk);
		hold_kick <= 1'b0;
		wait_idle();

		repeat (20) @(negedge clk);
		$display("checked %0d verdicts from %0d blobs (%0d beats), four idle/stall mixes,",
			verdicts_checked, blobs_sent, bytes_accepted);
		$display("accepted %0d truncated %0d bad header %0d identity %0d too large %0d checksum %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5]);
		if (error_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
